/* src/dpdd_pkg.sv */
// ============================================================================
// Dual PID differential drive package
// Shared widths, register map, motion mode codes and small helper functions
// for the dual PID differential drive controller.
// ============================================================================
`default_nettype none

package dpdd_pkg;

  // Gain format and integrator size.
  localparam int unsigned GAIN_FRAC_BITS = 6;
  localparam int unsigned GAIN_W         = 10;
  localparam int unsigned INTEGRAL_WIDTH = 40;

  // Field widths of the input and result words.
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned LINE_W   = 13;
  localparam int unsigned DRV_W    = 16;
  localparam int unsigned GAINS_W  = 6 * GAIN_W;
  localparam int unsigned LIMITS_W = 3 * DRV_W;

  // Internal datapath widths.
  localparam int unsigned SP_W      = 10;
  localparam int unsigned ROT_SP_W  = 11;
  localparam int unsigned RPM_SUM_W = RPM_W + 1;
  localparam int unsigned ERR_W     = 18;
  localparam int unsigned DERR_W    = ERR_W + 1;
  localparam int unsigned PROD_W    = ERR_W + GAIN_W + 1;
  localparam int unsigned DPROD_W   = DERR_W + GAIN_W + 1;
  localparam int unsigned PD_W      = 32;
  localparam int unsigned SUM_W     = INTEGRAL_WIDTH + 2;
  localparam int unsigned MIX_W     = DRV_W + 1;

  // Line offset and division by seven through a reciprocal multiply.
  localparam int unsigned LINE_OFF_W = LINE_W + 1;
  localparam int unsigned LINE_MAG_W = LINE_W;
  localparam int unsigned DIV7_SHIFT = 16;
  localparam int unsigned DIV7_MUL   = 9363;
  localparam int unsigned DIV_PROD_W = DIV7_SHIFT + ROT_SP_W;

  localparam logic [LINE_OFF_W-1:0] LINE_CENTER = LINE_OFF_W'(3500);

  // Translational setpoints.
  localparam logic [SP_W-1:0] SP_STRAIGHT = SP_W'(900);
  localparam logic [SP_W-1:0] SP_CURVE    = SP_W'(1000);

  // Rounding mask for truncation toward zero.
  localparam logic signed [SUM_W-1:0] FRAC_MASK = SUM_W'((1 << GAIN_FRAC_BITS) - 1);

  // Configuration port.
  localparam int unsigned ADDR_W = 6;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned REG_LSB = 3;

  localparam logic [ADDR_W-REG_LSB-1:0] REG_GAINS_STRAIGHT  = 3'd0;
  localparam logic [ADDR_W-REG_LSB-1:0] REG_GAINS_CURVE     = 3'd1;
  localparam logic [ADDR_W-REG_LSB-1:0] REG_GAINS_STOPPED   = 3'd2;
  localparam logic [ADDR_W-REG_LSB-1:0] REG_LIMITS_STRAIGHT = 3'd3;
  localparam logic [ADDR_W-REG_LSB-1:0] REG_LIMITS_CURVE    = 3'd4;
  localparam logic [ADDR_W-REG_LSB-1:0] REG_LIMITS_STOPPED  = 3'd5;

  // Gain slots inside a packed gain register.
  localparam int unsigned KP_T = 0;
  localparam int unsigned KI_T = 1;
  localparam int unsigned KD_T = 2;
  localparam int unsigned KP_R = 3;
  localparam int unsigned KI_R = 4;
  localparam int unsigned KD_R = 5;

  // Slots inside a packed limit register.
  localparam int unsigned LIM_BASE = 0;
  localparam int unsigned LIM_MIN  = 1;
  localparam int unsigned LIM_MAX  = 2;

  // Motion modes; the unused code behaves as stopped.
  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_CURVE    = 2'd1,
    MODE_STOPPED  = 2'd2
  } mode_e;

  // One gain of a packed gain register, as a signed operand.
  function automatic logic signed [GAIN_W:0] gain_of(input logic [GAINS_W-1:0] g,
                                                     input int unsigned k);
    return $signed({1'b0, g[GAIN_W*k +: GAIN_W]});
  endfunction

  // One signed field of a packed limit register.
  function automatic logic signed [DRV_W-1:0] limit_of(input logic [LIMITS_W-1:0] l,
                                                       input int unsigned k);
    return $signed(l[DRV_W*k +: DRV_W]);
  endfunction

  // Saturate a one-bit-wider sum to the integrator width.
  function automatic logic signed [INTEGRAL_WIDTH-1:0] sat_integ(
      input logic signed [INTEGRAL_WIDTH:0] x);
    logic signed [INTEGRAL_WIDTH-1:0] res;
    if (x[INTEGRAL_WIDTH] != x[INTEGRAL_WIDTH-1]) begin
      res = x[INTEGRAL_WIDTH] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
                              : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
    end else begin
      res = x[INTEGRAL_WIDTH-1:0];
    end
    return res;
  endfunction

  // Clamp a mixed drive: the minimum test wins over the maximum test.
  function automatic logic signed [DRV_W-1:0] drv_clamp(input logic signed [MIX_W-1:0] x,
                                                        input logic signed [DRV_W-1:0] lo,
                                                        input logic signed [DRV_W-1:0] hi);
    logic signed [DRV_W-1:0] res;
    if (x < MIX_W'(lo)) begin
      res = lo;
    end else if (x > MIX_W'(hi)) begin
      res = hi;
    end else begin
      res = x[DRV_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/dual_pid_differential_drive_top.sv */
// ============================================================================
// Dual PID differential drive controller
// Translational and rotational PID loops with per-mode gains and limits,
// mixed into clamped right and left motor drives.
// ============================================================================
//
// Usage: one input word per control tick carries the motion mode, the map
// flag, both wheel speeds and the line position. It is accepted at a clock
// edge where in_valid_i is high and in_stall_o is low. One result word with
// both drives, the translational drive and the rotational drive comes back
// for each input word, on out_valid_o, and is taken when out_stall_i is low.
// A word passes through the five-register pipeline (input, products,
// integrators, loop outputs, mixed drives) to the output register.
// Throughput is one word per cycle while in_stall_o stays low; the
// integrators close their loop through their own register.
// When the receiver stalls, words keep moving into empty stages; in_stall_o
// rises only when all five stages hold a word. Reset clears the setpoint,
// both integrators, both previous errors, all gain and limit registers and
// the pipeline. Gains and limits are written over the APB port at byte
// address 8*index. The user must do so only while no word is in flight; the block does not enforce it.
//
`default_nettype none

module dual_pid_differential_drive_top (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // Input channel.
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [1:0]                             motion_mode_i,
  input  wire logic                                   map_flag_i,
  input  wire logic signed [dpdd_pkg::RPM_W-1:0]      rpm_right_i,
  input  wire logic signed [dpdd_pkg::RPM_W-1:0]      rpm_left_i,
  input  wire logic [dpdd_pkg::LINE_W-1:0]            line_position_i,
  // Result channel.
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [dpdd_pkg::DRV_W-1:0]           drive_right_o,
  output logic signed [dpdd_pkg::DRV_W-1:0]           drive_left_o,
  output logic signed [dpdd_pkg::DRV_W-1:0]           trans_drive_o,
  output logic signed [dpdd_pkg::DRV_W-1:0]           rot_drive_o,
  // Configuration port.
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [dpdd_pkg::ADDR_W-1:0]            paddr,
  input  wire logic [dpdd_pkg::DATA_W-1:0]            pwdata,
  output logic [dpdd_pkg::DATA_W-1:0]                 prdata,
  output logic                                        pready
);

  import dpdd_pkg::*;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  logic [GAINS_W-1:0]  gains_q  [3];
  logic [LIMITS_W-1:0] limits_q [3];
  logic                cfg_write;
  logic [ADDR_W-REG_LSB-1:0] reg_idx;

  // Pipeline valids and flow control.
  logic s0_valid_q, s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s0_free, s1_free, s2_free, s3_free, out_free;
  logic in_take, take0, take1, take2, take3;

  // Input side: rotational setpoint from the line position.
  logic signed [LINE_OFF_W-1:0] line_off;
  logic [LINE_MAG_W-1:0]        line_mag;
  logic [DIV_PROD_W-1:0]        div_prod;
  logic [ROT_SP_W-1:0]          div_q;
  logic signed [ROT_SP_W-1:0]   rot_sp_d;

  // Stage 0 registers.
  logic [1:0]                 s0_mode_q;
  logic                       s0_map_q;
  logic signed [RPM_W-1:0]    s0_rpm_r_q;
  logic signed [RPM_W-1:0]    s0_rpm_l_q;
  logic signed [ROT_SP_W-1:0] s0_rot_sp_q;

  // Loop state.
  logic [SP_W-1:0]                   sp_q, sp_d;
  logic signed [ERR_W-1:0]           prev_t_q, prev_r_q;
  logic signed [INTEGRAL_WIDTH-1:0]  integ_t_q, integ_r_q;

  // Stage 1 logic and registers.
  logic [1:0]                  s0_sel;
  logic [GAINS_W-1:0]          g1;
  logic signed [RPM_SUM_W-1:0] rpm_sum, rpm_diff;
  logic signed [ERR_W-1:0]     e_t, e_r;
  logic signed [DERR_W-1:0]    de_t, de_r;
  logic signed [PROD_W-1:0]    s1_p_t_q, s1_i_t_q, s1_p_r_q, s1_i_r_q;
  logic signed [DPROD_W-1:0]   s1_d_t_q, s1_d_r_q;
  logic                        s1_stop_q;
  logic [1:0]                  s1_sel_q;

  // Stage 2 logic and registers.
  logic [LIMITS_W-1:0]               lim2;
  logic signed [INTEGRAL_WIDTH-1:0]  integ_t_base, integ_r_base;
  logic signed [INTEGRAL_WIDTH:0]    integ_t_sum, integ_r_sum;
  logic signed [PD_W-1:0]            pd_t_d, pd_r_d;
  logic signed [PD_W-1:0]            s2_pd_t_q, s2_pd_r_q;
  logic [1:0]                        s2_sel_q;

  // Stage 3 logic and registers.
  logic [LIMITS_W-1:0]      lim3;
  logic signed [SUM_W-1:0]  s_t, s_r, lo_sh, hi_sh, t_clip, t_adj, t_shr, r_adj, r_shr;
  logic signed [DRV_W-1:0]  trans_d, rot_d;
  logic signed [DRV_W-1:0]  s3_trans_q, s3_rot_q;
  logic [1:0]               s3_sel_q;

  // Output stage.
  logic [LIMITS_W-1:0]      lim4;
  logic signed [MIX_W-1:0]  mix_r, mix_l;
  logic signed [DRV_W-1:0]  drive_right_q, drive_left_q, trans_drive_q, rot_drive_q;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  assign reg_idx   = paddr[ADDR_W-1:REG_LSB];
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q[MODE_STRAIGHT]  <= '0;
      gains_q[MODE_CURVE]     <= '0;
      gains_q[MODE_STOPPED]   <= '0;
      limits_q[MODE_STRAIGHT] <= '0;
      limits_q[MODE_CURVE]    <= '0;
      limits_q[MODE_STOPPED]  <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_GAINS_STRAIGHT:  gains_q[MODE_STRAIGHT]  <= pwdata[GAINS_W-1:0];
        REG_GAINS_CURVE:     gains_q[MODE_CURVE]     <= pwdata[GAINS_W-1:0];
        REG_GAINS_STOPPED:   gains_q[MODE_STOPPED]   <= pwdata[GAINS_W-1:0];
        REG_LIMITS_STRAIGHT: limits_q[MODE_STRAIGHT] <= pwdata[LIMITS_W-1:0];
        REG_LIMITS_CURVE:    limits_q[MODE_CURVE]    <= pwdata[LIMITS_W-1:0];
        REG_LIMITS_STOPPED:  limits_q[MODE_STOPPED]  <= pwdata[LIMITS_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_GAINS_STRAIGHT:  prdata = DATA_W'(gains_q[MODE_STRAIGHT]);
      REG_GAINS_CURVE:     prdata = DATA_W'(gains_q[MODE_CURVE]);
      REG_GAINS_STOPPED:   prdata = DATA_W'(gains_q[MODE_STOPPED]);
      REG_LIMITS_STRAIGHT: prdata = DATA_W'(limits_q[MODE_STRAIGHT]);
      REG_LIMITS_CURVE:    prdata = DATA_W'(limits_q[MODE_CURVE]);
      REG_LIMITS_STOPPED:  prdata = DATA_W'(limits_q[MODE_STOPPED]);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: a stage loads when it is empty or its word moves on.
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || !out_stall_i;
  assign s3_free  = !s3_valid_q || out_free;
  assign s2_free  = !s2_valid_q || s3_free;
  assign s1_free  = !s1_valid_q || s2_free;
  assign s0_free  = !s0_valid_q || s1_free;

  assign take3   = s3_valid_q && out_free;
  assign take2   = s2_valid_q && s3_free;
  assign take1   = s1_valid_q && s2_free;
  assign take0   = s0_valid_q && s1_free;
  assign in_take = in_valid_i && s0_free;

  assign in_stall_o = !s0_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_free)  s0_valid_q  <= in_valid_i;
      if (s1_free)  s1_valid_q  <= s0_valid_q;
      if (s2_free)  s2_valid_q  <= s1_valid_q;
      if (s3_free)  s3_valid_q  <= s2_valid_q;
      if (out_free) out_valid_q <= s3_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Input register. The rotational setpoint (3500 - line) / 7 is formed on
  // the way in: magnitude times a reciprocal of seven, then the sign back.
  // --------------------------------------------------------------------------
  assign line_off = $signed(LINE_CENTER) - $signed({1'b0, line_position_i});
  assign line_mag = line_off[LINE_OFF_W-1] ? LINE_MAG_W'(-line_off)
                                           : line_off[LINE_MAG_W-1:0];
  assign div_prod = DIV_PROD_W'(line_mag) * DIV_PROD_W'(DIV7_MUL);
  assign div_q    = div_prod[DIV_PROD_W-1:DIV7_SHIFT];
  assign rot_sp_d = line_off[LINE_OFF_W-1] ? -$signed(div_q) : $signed(div_q);

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s0_mode_q   <= motion_mode_i;
      s0_map_q    <= map_flag_i;
      s0_rpm_r_q  <= rpm_right_i;
      s0_rpm_l_q  <= rpm_left_i;
      s0_rot_sp_q <= rot_sp_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: setpoint update, loop errors and gain products.
  // --------------------------------------------------------------------------
  assign s0_sel = s0_mode_q[1] ? MODE_STOPPED : s0_mode_q;
  assign g1     = gains_q[s0_sel];

  // A moving car in map mode always runs at the curve setpoint.
  always_comb begin
    case (mode_e'(s0_mode_q))
      MODE_STRAIGHT: sp_d = s0_map_q ? SP_CURVE : SP_STRAIGHT;
      MODE_CURVE:    sp_d = SP_CURVE;
      default:       sp_d = sp_q;
    endcase
  end

  assign rpm_sum  = RPM_SUM_W'(s0_rpm_r_q) + RPM_SUM_W'(s0_rpm_l_q);
  assign rpm_diff = RPM_SUM_W'(s0_rpm_r_q) - RPM_SUM_W'(s0_rpm_l_q);
  assign e_t      = ERR_W'($signed({1'b0, sp_d})) - ERR_W'(rpm_sum);
  assign e_r      = ERR_W'(s0_rot_sp_q) - ERR_W'(rpm_diff);
  assign de_t     = DERR_W'(e_t) - DERR_W'(prev_t_q);
  assign de_r     = DERR_W'(e_r) - DERR_W'(prev_r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      prev_t_q <= '0;
      prev_r_q <= '0;
    end else if (take0) begin
      sp_q     <= sp_d;
      prev_t_q <= e_t;
      prev_r_q <= e_r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take0) begin
      s1_p_t_q  <= PROD_W'(gain_of(g1, KP_T)) * PROD_W'(e_t);
      s1_i_t_q  <= PROD_W'(gain_of(g1, KI_T)) * PROD_W'(e_t);
      s1_d_t_q  <= DPROD_W'(gain_of(g1, KD_T)) * DPROD_W'(de_t);
      s1_p_r_q  <= PROD_W'(gain_of(g1, KP_R)) * PROD_W'(e_r);
      s1_i_r_q  <= PROD_W'(gain_of(g1, KI_R)) * PROD_W'(e_r);
      s1_d_r_q  <= DPROD_W'(gain_of(g1, KD_R)) * DPROD_W'(de_r);
      s1_stop_q <= s0_mode_q[1];
      s1_sel_q  <= s0_sel;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: integrator update (cleared first when stopped) and the
  // proportional plus derivative sums, with the base speed on the
  // translational side.
  // --------------------------------------------------------------------------
  assign lim2         = limits_q[s1_sel_q];
  assign integ_t_base = s1_stop_q ? '0 : integ_t_q;
  assign integ_r_base = s1_stop_q ? '0 : integ_r_q;
  assign integ_t_sum  = (INTEGRAL_WIDTH+1)'(integ_t_base) + (INTEGRAL_WIDTH+1)'(s1_i_t_q);
  assign integ_r_sum  = (INTEGRAL_WIDTH+1)'(integ_r_base) + (INTEGRAL_WIDTH+1)'(s1_i_r_q);
  assign pd_t_d = PD_W'(s1_p_t_q) + PD_W'(s1_d_t_q)
                + (PD_W'(limit_of(lim2, LIM_BASE)) <<< GAIN_FRAC_BITS);
  assign pd_r_d = PD_W'(s1_p_r_q) + PD_W'(s1_d_r_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_t_q <= '0;
      integ_r_q <= '0;
    end else if (take1) begin
      integ_t_q <= sat_integ(integ_t_sum);
      integ_r_q <= sat_integ(integ_r_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take1) begin
      s2_pd_t_q <= pd_t_d;
      s2_pd_r_q <= pd_r_d;
      s2_sel_q  <= s1_sel_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: loop outputs. The translational sum is clamped to the scaled
  // limits, then both sums are truncated toward zero to whole drive units.
  // --------------------------------------------------------------------------
  assign lim3  = limits_q[s2_sel_q];
  assign s_t   = SUM_W'(integ_t_q) + SUM_W'(s2_pd_t_q);
  assign s_r   = SUM_W'(integ_r_q) + SUM_W'(s2_pd_r_q);
  assign lo_sh = SUM_W'(limit_of(lim3, LIM_MIN)) <<< GAIN_FRAC_BITS;
  assign hi_sh = SUM_W'(limit_of(lim3, LIM_MAX)) <<< GAIN_FRAC_BITS;

  always_comb begin
    if (s_t < lo_sh) begin
      t_clip = lo_sh;
    end else if (s_t > hi_sh) begin
      t_clip = hi_sh;
    end else begin
      t_clip = s_t;
    end
  end

  assign t_adj   = t_clip[SUM_W-1] ? t_clip + FRAC_MASK : t_clip;
  assign t_shr   = t_adj >>> GAIN_FRAC_BITS;
  assign trans_d = t_shr[DRV_W-1:0];

  assign r_adj = s_r[SUM_W-1] ? s_r + FRAC_MASK : s_r;
  assign r_shr = r_adj >>> GAIN_FRAC_BITS;

  // Saturate the rotational output when the upper bits are not a sign run.
  always_comb begin
    if ((&r_shr[SUM_W-1:DRV_W-1]) || !(|r_shr[SUM_W-1:DRV_W-1])) begin
      rot_d = r_shr[DRV_W-1:0];
    end else begin
      rot_d = r_shr[SUM_W-1] ? {1'b1, {(DRV_W-1){1'b0}}} : {1'b0, {(DRV_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (take2) begin
      s3_trans_q <= trans_d;
      s3_rot_q   <= rot_d;
      s3_sel_q   <= s2_sel_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: mix into right and left drives, each clamped.
  // --------------------------------------------------------------------------
  assign lim4  = limits_q[s3_sel_q];
  assign mix_r = MIX_W'(s3_trans_q) + MIX_W'(s3_rot_q);
  assign mix_l = MIX_W'(s3_trans_q) - MIX_W'(s3_rot_q);

  always_ff @(posedge clk_i) begin
    if (take3) begin
      drive_right_q <= drv_clamp(mix_r, limit_of(lim4, LIM_MIN), limit_of(lim4, LIM_MAX));
      drive_left_q  <= drv_clamp(mix_l, limit_of(lim4, LIM_MIN), limit_of(lim4, LIM_MAX));
      trans_drive_q <= s3_trans_q;
      rot_drive_q   <= s3_rot_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drive_right_o = drive_right_q;
  assign drive_left_o  = drive_left_q;
  assign trans_drive_o = trans_drive_q;
  assign rot_drive_o   = rot_drive_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  // The input side stalls only when every stage holds a word.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s0_valid_q && s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q))
    else $error("input stalled while a pipeline stage is empty");

  // The setpoint only ever takes its reset value or one of the two speeds.
  a_sp_values: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sp_q == '0) || (sp_q == SP_STRAIGHT) || (sp_q == SP_CURVE))
    else $error("translational setpoint holds an unexpected value");

  // A stopped word leaves the setpoint untouched.
  a_sp_hold_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take0 && s0_mode_q[1]) |=> (sp_q == $past(sp_q)))
    else $error("setpoint changed on a stopped word");

  // A stopped word restarts both integrators from its own integral term.
  a_integ_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take1 && s1_stop_q) |=> ((integ_t_q == INTEGRAL_WIDTH'($past(s1_i_t_q)))
                              && (integ_r_q == INTEGRAL_WIDTH'($past(s1_i_r_q)))))
    else $error("integrator not cleared on a stopped word");
`endif

endmodule

`default_nettype wire

/* tb/sv/dual_pid_drive_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// Dual PID drive checker
// Watches the configuration port and both word channels of the dual PID
// differential drive controller. It keeps its own copy of the gains, limits,
// setpoint, integrators and previous errors, works out the drive word that
// each accepted input word must produce, and compares the returned words
// field by field in order.
// ============================================================================

module dual_pid_drive_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input channel.
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [1:0]                          motion_mode_i,
  input  logic                                map_flag_i,
  input  logic signed [dpdd_pkg::RPM_W-1:0]   rpm_right_i,
  input  logic signed [dpdd_pkg::RPM_W-1:0]   rpm_left_i,
  input  logic [dpdd_pkg::LINE_W-1:0]         line_position_i,
  // Result channel.
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic signed [dpdd_pkg::DRV_W-1:0]   drive_right_i,
  input  logic signed [dpdd_pkg::DRV_W-1:0]   drive_left_i,
  input  logic signed [dpdd_pkg::DRV_W-1:0]   trans_drive_i,
  input  logic signed [dpdd_pkg::DRV_W-1:0]   rot_drive_i,
  // Configuration port.
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic                                pready_i,
  input  logic [dpdd_pkg::ADDR_W-1:0]         paddr_i,
  input  logic [dpdd_pkg::DATA_W-1:0]         pwdata_i,
  // Status toward the testbench top.
  output int                                  outstanding_o,
  output int                                  mismatches_o
);

  import dpdd_pkg::*;

  localparam longint FRAC_ONE   = 64'sd1 <<< GAIN_FRAC_BITS;
  localparam longint INTEG_MAX  = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 1;
  localparam longint INTEG_MIN  = -INTEG_MAX - 1;
  localparam longint SUM_MAX    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN    = -SUM_MAX - 1;
  localparam longint DRV_MAX    = 32767;
  localparam longint DRV_MIN    = -32768;
  localparam longint SPEED_LINE = 900;
  localparam longint SPEED_BEND = 1000;
  localparam longint SENSOR_MID = 3500;
  localparam longint SENSOR_DIV = 7;

  typedef struct packed {
    logic signed [DRV_W-1:0] right;
    logic signed [DRV_W-1:0] left;
    logic signed [DRV_W-1:0] trans;
    logic signed [DRV_W-1:0] rot;
  } drive_word_t;

  // Shadow of the configuration, indexed by motion mode.
  logic [GAINS_W-1:0]  mode_gains  [3];
  logic [LIMITS_W-1:0] mode_limits [3];

  // Shadow of the loop state.
  logic [SP_W-1:0] speed_sp;
  longint          trans_acc;
  longint          rot_acc;
  longint          trans_last_err;
  longint          rot_last_err;

  drive_word_t pending_drives[$];
  int          fail_total = 0;

  // Add two 64-bit values, saturating on overflow.
  function automatic longint sat_sum(input longint a, input longint b);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) return SUM_MAX;
    if (a < 0 && b < 0 && s >= 0) return SUM_MIN;
    return s;
  endfunction

  // The lower bound is tested first, so it wins when the bounds cross.
  function automatic longint bound(input longint x, input longint lo, input longint hi);
    if (x < lo) return lo;
    if (x > hi) return hi;
    return x;
  endfunction

  function automatic longint gain_at(input logic [GAINS_W-1:0] g, input int k);
    return longint'(g[k*GAIN_W +: GAIN_W]);
  endfunction

  function automatic longint limit_at(input logic [LIMITS_W-1:0] l, input int k);
    logic signed [DRV_W-1:0] v;
    v = l[k*DRV_W +: DRV_W];
    return longint'(v);
  endfunction

  // One control tick: update the loop state and return the drive word.
  function automatic drive_word_t next_drive_word(input logic [1:0] mode_bits,
                                                  input logic map,
                                                  input logic signed [RPM_W-1:0] rr,
                                                  input logic signed [RPM_W-1:0] rl,
                                                  input logic [LINE_W-1:0] line);
    mode_e               mode;
    mode_e               sel;
    bit                  halted;
    logic [GAINS_W-1:0]  g;
    logic [LIMITS_W-1:0] lim;
    longint              base, lo, hi, e_t, e_r, s_t, s_r, t_out, r_out;
    drive_word_t         w;
    mode   = mode_e'(mode_bits);
    halted = (mode != MODE_STRAIGHT) && (mode != MODE_CURVE);
    sel    = halted ? MODE_STOPPED : mode;
    g      = mode_gains[sel];
    lim    = mode_limits[sel];
    base   = limit_at(lim, LIM_BASE);
    lo     = limit_at(lim, LIM_MIN);
    hi     = limit_at(lim, LIM_MAX);

    // Setpoint: a stopped car keeps the old one.
    if (!map && mode == MODE_STRAIGHT) begin
      speed_sp = SP_W'(SPEED_LINE);
    end else if (!map && mode == MODE_CURVE) begin
      speed_sp = SP_W'(SPEED_BEND);
    end else if (map && !halted) begin
      speed_sp = SP_W'(SPEED_BEND);
    end

    if (halted) begin
      trans_acc = 0;
      rot_acc   = 0;
    end

    e_t = longint'(speed_sp) - (longint'(rr) + longint'(rl));
    e_r = (SENSOR_MID - longint'(line)) / SENSOR_DIV - (longint'(rr) - longint'(rl));

    // Translational loop.
    trans_acc = bound(sat_sum(trans_acc, gain_at(g, KI_T) * e_t), INTEG_MIN, INTEG_MAX);
    s_t = sat_sum(gain_at(g, KP_T) * e_t, trans_acc);
    s_t = sat_sum(s_t, gain_at(g, KD_T) * (e_t - trans_last_err));
    trans_last_err = e_t;

    // Rotational loop.
    rot_acc = bound(sat_sum(rot_acc, gain_at(g, KI_R) * e_r), INTEG_MIN, INTEG_MAX);
    s_r = sat_sum(gain_at(g, KP_R) * e_r, rot_acc);
    s_r = sat_sum(s_r, gain_at(g, KD_R) * (e_r - rot_last_err));
    rot_last_err = e_r;

    // Offset, clamp and mix; division truncates toward zero.
    s_t   = sat_sum(s_t, base * FRAC_ONE);
    t_out = bound(s_t, lo * FRAC_ONE, hi * FRAC_ONE) / FRAC_ONE;
    r_out = bound(s_r / FRAC_ONE, DRV_MIN, DRV_MAX);

    w.right = DRV_W'(bound(t_out + r_out, lo, hi));
    w.left  = DRV_W'(bound(t_out - r_out, lo, hi));
    w.trans = DRV_W'(t_out);
    w.rot   = DRV_W'(r_out);
    return w;
  endfunction

  task automatic check_field(input string name, input logic signed [DRV_W-1:0] want,
                             input logic signed [DRV_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_total++;
    end
  endtask

  // Sample both channels and the configuration port at each rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    drive_word_t want;
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        mode_gains[k]  = '0;
        mode_limits[k] = '0;
      end
      speed_sp       = '0;
      trans_acc      = 0;
      rot_acc        = 0;
      trans_last_err = 0;
      rot_last_err   = 0;
      pending_drives.delete();
      outstanding_o <= 0;
      mismatches_o  <= fail_total;
    end else begin
      // Register writes.
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:REG_LSB])
          REG_GAINS_STRAIGHT:  mode_gains[MODE_STRAIGHT]  = pwdata_i[GAINS_W-1:0];
          REG_GAINS_CURVE:     mode_gains[MODE_CURVE]     = pwdata_i[GAINS_W-1:0];
          REG_GAINS_STOPPED:   mode_gains[MODE_STOPPED]   = pwdata_i[GAINS_W-1:0];
          REG_LIMITS_STRAIGHT: mode_limits[MODE_STRAIGHT] = pwdata_i[LIMITS_W-1:0];
          REG_LIMITS_CURVE:    mode_limits[MODE_CURVE]    = pwdata_i[LIMITS_W-1:0];
          REG_LIMITS_STOPPED:  mode_limits[MODE_STOPPED]  = pwdata_i[LIMITS_W-1:0];
          default: ;
        endcase
      end

      // Returned drive words.
      if (out_valid_i && !out_stall_i) begin
        if (pending_drives.size() == 0) begin
          $error("drive word returned with none outstanding");
          fail_total++;
        end else begin
          want = pending_drives.pop_front();
          check_field("drive_right", want.right, drive_right_i);
          check_field("drive_left", want.left, drive_left_i);
          check_field("trans_drive", want.trans, trans_drive_i);
          check_field("rot_drive", want.rot, rot_drive_i);
        end
      end

      // Accepted input words.
      if (in_valid_i && !in_stall_i) begin
        pending_drives.push_back(next_drive_word(motion_mode_i, map_flag_i, rpm_right_i,
                                                 rpm_left_i, line_position_i));
      end

      outstanding_o <= pending_drives.size();
      mismatches_o  <= fail_total;
    end
  end

endmodule

/* tb/sv/tb_dual_pid_differential_drive_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// Dual PID differential drive testbench
// Drives control ticks into the controller under several gain and limit
// settings, with random gaps on the input side and random stalls on the
// result side, and lets the checker compare every drive word. Runs of
// extreme wheel speeds drive both integrators hard in each direction.
// ============================================================================

module tb_dual_pid_differential_drive_top;
  import dpdd_pkg::*;

  localparam int          CYCLE_LIMIT  = 50000;
  localparam int          WINDUP_TICKS = 20;
  localparam int          TICKS_PER_SET = 90;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;
  localparam int          RPM_MIN      = -32768;
  localparam int          RPM_MAX      = 32767;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               motion_mode_i = '0;
  logic                     map_flag_i = 1'b0;
  logic signed [RPM_W-1:0]  rpm_right_i = '0;
  logic signed [RPM_W-1:0]  rpm_left_i = '0;
  logic [LINE_W-1:0]        line_position_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [DRV_W-1:0]  drive_right_o;
  logic signed [DRV_W-1:0]  drive_left_o;
  logic signed [DRV_W-1:0]  trans_drive_o;
  logic signed [DRV_W-1:0]  rot_drive_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [ADDR_W-1:0]        paddr = '0;
  logic [DATA_W-1:0]        pwdata = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  int outstanding;
  int fail_count;
  int cycle_count = 0;
  int send_idle_pct = 17;
  int recv_idle_pct = 48;

  dual_pid_differential_drive_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .motion_mode_i   (motion_mode_i),
    .map_flag_i      (map_flag_i),
    .rpm_right_i     (rpm_right_i),
    .rpm_left_i      (rpm_left_i),
    .line_position_i (line_position_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_right_o   (drive_right_o),
    .drive_left_o    (drive_left_o),
    .trans_drive_o   (trans_drive_o),
    .rot_drive_o     (rot_drive_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  dual_pid_drive_checker drive_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .motion_mode_i   (motion_mode_i),
    .map_flag_i      (map_flag_i),
    .rpm_right_i     (rpm_right_i),
    .rpm_left_i      (rpm_left_i),
    .line_position_i (line_position_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .drive_right_i   (drive_right_o),
    .drive_left_i    (drive_left_o),
    .trans_drive_i   (trans_drive_o),
    .rot_drive_i     (rot_drive_o),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .pready_i        (pready),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .outstanding_o   (outstanding),
    .mismatches_o    (fail_count)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Give up when the run takes far longer than any correct one could.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dual_pid_differential_drive_top verification failed");
      $finish;
    end
  end

  // Random stalls on the result side.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic logic [GAINS_W-1:0] pack_gains(input int kp_t, input int ki_t,
                                                    input int kd_t, input int kp_r,
                                                    input int ki_r, input int kd_r);
    return {GAIN_W'(kd_r), GAIN_W'(ki_r), GAIN_W'(kp_r),
            GAIN_W'(kd_t), GAIN_W'(ki_t), GAIN_W'(kp_t)};
  endfunction

  function automatic logic [LIMITS_W-1:0] pack_limits(input int base, input int lo,
                                                      input int hi);
    return {DRV_W'(hi), DRV_W'(lo), DRV_W'(base)};
  endfunction

  // Mostly small gains, with zero, full scale and wide values mixed in.
  function automatic logic [GAINS_W-1:0] pick_gains();
    logic [GAINS_W-1:0] g;
    int                 k;
    g = '0;
    for (k = 0; k < GAINS_W / GAIN_W; k++) begin
      case ($urandom_range(5))
        0:       g[k*GAIN_W +: GAIN_W] = '0;
        1:       g[k*GAIN_W +: GAIN_W] = '1;
        2:       g[k*GAIN_W +: GAIN_W] = GAIN_W'($urandom);
        default: g[k*GAIN_W +: GAIN_W] = GAIN_W'($urandom_range(96));
      endcase
    end
    return g;
  endfunction

  // Ordinary limits most of the time; full range, crossed bounds and
  // extreme base speeds now and then.
  function automatic logic [LIMITS_W-1:0] pick_limits();
    int base, lo, hi;
    base = int'($urandom_range(4000)) - 2000;
    lo   = -int'($urandom_range(32768));
    hi   = int'($urandom_range(32767));
    case ($urandom_range(7))
      0: begin
        lo = RPM_MIN;
        hi = RPM_MAX;
      end
      1: begin
        lo = int'($urandom_range(3000));
        hi = -int'($urandom_range(3000));
      end
      2: base = $urandom_range(1) ? RPM_MAX : RPM_MIN;
      default: ;
    endcase
    return pack_limits(base, lo, hi);
  endfunction

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [ADDR_W-REG_LSB-1:0] idx,
                           input logic [DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {REG_LSB{1'b0}}};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_settings(input logic [GAINS_W-1:0] g_line,
                               input logic [GAINS_W-1:0] g_bend,
                               input logic [GAINS_W-1:0] g_halt,
                               input logic [LIMITS_W-1:0] l_line,
                               input logic [LIMITS_W-1:0] l_bend,
                               input logic [LIMITS_W-1:0] l_halt);
    write_reg(REG_GAINS_STRAIGHT, DATA_W'(g_line));
    write_reg(REG_GAINS_CURVE, DATA_W'(g_bend));
    write_reg(REG_GAINS_STOPPED, DATA_W'(g_halt));
    write_reg(REG_LIMITS_STRAIGHT, DATA_W'(l_line));
    write_reg(REG_LIMITS_CURVE, DATA_W'(l_bend));
    write_reg(REG_LIMITS_STOPPED, DATA_W'(l_halt));
  endtask

  // Present one control tick and hold it until it is taken.
  task automatic send_tick(input logic [1:0] mode, input logic map,
                           input logic [RPM_W-1:0] rr, input logic [RPM_W-1:0] rl,
                           input logic [LINE_W-1:0] line);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    motion_mode_i   <= mode;
    map_flag_i      <= map;
    rpm_right_i     <= rr;
    rpm_left_i      <= rl;
    line_position_i <= line;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every drive word has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Runs of one mode with random speeds and line positions.
  task automatic random_ticks(input int count);
    logic [1:0]        mode;
    logic              map;
    logic [RPM_W-1:0]  rr, rl;
    logic [LINE_W-1:0] line;
    int                sent, run, j, half, dif;
    sent = 0;
    map  = 1'b0;
    while (sent < count) begin
      case ($urandom_range(9))
        0, 1, 2, 3: mode = MODE_STRAIGHT;
        4, 5, 6:    mode = MODE_CURVE;
        7, 8:       mode = MODE_STOPPED;
        default:    mode = MODE_UNUSED;
      endcase
      run = $urandom_range(20, 1);
      for (j = 0; j < run && sent < count; j++) begin
        if ($urandom_range(9) == 0) map = ~map;
        case ($urandom_range(9))
          0, 1: begin
            rr = RPM_W'($urandom);
            rl = RPM_W'($urandom);
          end
          2: begin
            rr = $urandom_range(1) ? RPM_W'(RPM_MAX) : RPM_W'(RPM_MIN);
            rl = $urandom_range(1) ? RPM_W'(RPM_MAX) : RPM_W'(RPM_MIN);
          end
          default: begin
            // Wheels near the cruising speed, turning a little.
            half = int'($urandom_range(600)) - 50;
            dif  = int'($urandom_range(400)) - 200;
            rr   = RPM_W'(half + dif);
            rl   = RPM_W'(half - dif);
          end
        endcase
        if ($urandom_range(9) == 0) line = LINE_W'($urandom_range(8191, 7001));
        else line = LINE_W'($urandom_range(7000));
        send_tick(mode, map, rr, rl, line);
        sent++;
      end
    end
  endtask

  // Clear the integrators with a stopped tick, then hold the wheel speeds
  // near fixed extremes for a run of ticks.
  task automatic wind_up(input int rr_base, input int rl_base, input int line);
    int n;
    send_tick(MODE_STOPPED, 1'b0, '0, '0, LINE_W'(line));
    for (n = 0; n < WINDUP_TICKS; n++) begin
      send_tick(MODE_STRAIGHT, 1'b0, RPM_W'(rr_base + int'($urandom_range(27))),
                RPM_W'(rl_base + int'($urandom_range(27))), LINE_W'(line));
    end
  endtask

  initial begin
    int phase, set_idx;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: all gains and limits are zero.
    send_tick(MODE_STRAIGHT, 1'b0, RPM_W'(RPM_MAX), RPM_W'(RPM_MIN), LINE_W'(0));
    send_tick(MODE_CURVE, 1'b1, RPM_W'(RPM_MIN), RPM_W'(RPM_MAX), LINE_W'(7000));
    send_tick(MODE_STOPPED, 1'b0, 16'd1234, 16'd321, LINE_W'(3500));
    drain();

    // Moderate straight gains, full-scale curve gains, zero stopped gains;
    // full-range straight limits, crossed curve limits.
    load_settings(pack_gains(64, 8, 16, 64, 4, 32), '1, '0,
                  pack_limits(0, RPM_MIN, RPM_MAX), pack_limits(300, 500, -500),
                  pack_limits(RPM_MIN, -100, 100));

    send_tick(MODE_STRAIGHT, 1'b0, 16'd0, 16'd0, LINE_W'(3500));
    send_tick(MODE_STRAIGHT, 1'b0, RPM_W'(RPM_MAX), RPM_W'(RPM_MIN), LINE_W'(0));
    send_tick(MODE_STRAIGHT, 1'b0, RPM_W'(RPM_MIN), RPM_W'(RPM_MAX), LINE_W'(7000));
    send_tick(MODE_STRAIGHT, 1'b1, 16'd450, 16'd450, LINE_W'(3500));
    send_tick(MODE_CURVE, 1'b0, 16'd500, 16'd480, LINE_W'(3000));
    // Line positions past the sensor range.
    send_tick(MODE_CURVE, 1'b1, RPM_W'(RPM_MAX), RPM_W'(RPM_MAX), LINE_W'(8191));
    send_tick(MODE_CURVE, 1'b0, RPM_W'(RPM_MIN), RPM_W'(RPM_MIN), LINE_W'(7001));
    // Stopped keeps the setpoint and clears both integrators.
    send_tick(MODE_STOPPED, 1'b0, 16'd100, -16'sd100, LINE_W'(3500));
    send_tick(MODE_STOPPED, 1'b1, 16'd40, 16'd60, LINE_W'(2000));
    send_tick(MODE_STRAIGHT, 1'b1, 16'd10, 16'd20, LINE_W'(3500));
    // The unused mode code behaves as stopped.
    send_tick(MODE_UNUSED, 1'b0, 16'd700, 16'd300, LINE_W'(100));
    send_tick(MODE_UNUSED, 1'b1, -16'sd1, 16'd1, LINE_W'(4095));
    // Rotational setpoint truncation toward zero on both sides of center.
    send_tick(MODE_STRAIGHT, 1'b0, 16'd0, 16'd0, LINE_W'(1));
    send_tick(MODE_STRAIGHT, 1'b0, 16'd0, 16'd0, LINE_W'(6999));
    send_tick(MODE_CURVE, 1'b0, 16'd1, -16'sd1, LINE_W'(3501));
    send_tick(MODE_STRAIGHT, 1'b0, 16'd1, -16'sd1, LINE_W'(3499));
    send_tick(MODE_CURVE, 1'b1, 16'd20000, -16'sd20000, LINE_W'(5000));
    send_tick(MODE_STOPPED, 1'b0, RPM_W'(RPM_MAX), RPM_W'(RPM_MAX), LINE_W'(0));
    send_tick(MODE_STRAIGHT, 1'b0, RPM_W'(RPM_MIN), RPM_W'(RPM_MIN), LINE_W'(8191));

    // Random ticks under fresh settings; the idle mix changes per phase.
    for (phase = 0; phase < 3; phase++) begin
      for (set_idx = 0; set_idx < 3; set_idx++) begin
        drain();
        case (phase)
          0: begin
            send_idle_pct = 17;
            recv_idle_pct = 48;
          end
          1: begin
            send_idle_pct = 48;
            recv_idle_pct = 17;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        load_settings(pick_gains(), pick_gains(), pick_gains(),
                      pick_limits(), pick_limits(), pick_limits());
        random_ticks(TICKS_PER_SET);
      end
    end

    // Integrator stress: full-scale integral gains, each loop driven hard
    // in each direction.
    drain();
    write_reg(REG_GAINS_STRAIGHT, DATA_W'(pack_gains(16, 1023, 8, 16, 1023, 8)));
    write_reg(REG_LIMITS_STRAIGHT, DATA_W'(pack_limits(0, RPM_MIN, RPM_MAX)));
    wind_up(RPM_MIN, RPM_MIN, 3500);
    wind_up(RPM_MAX - 27, RPM_MAX - 27, 3500);
    wind_up(RPM_MAX - 27, RPM_MIN, 7000);
    wind_up(RPM_MIN, RPM_MAX - 27, 0);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("dual_pid_differential_drive_top verification clean");
    end else begin
      $display("dual_pid_differential_drive_top verification failed");
    end
    $finish;
  end

endmodule
